[rtl/wvpi_pkg.sv]
package wvpi_pkg;

    localparam int VEL_W      = 16;
    localparam int DUTY_W     = 16;
    localparam int DT_W       = 16;
    localparam int GAIN_W     = 32;
    localparam int SLEW_W     = 24;
    localparam int KICK_W     = 15;
    localparam int INT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // velocity error, one bit wider than a velocity
    localparam int ERR_W      = VEL_W + 1;
    // shared multiplier operand and the accumulator at 2^-32 duty resolution
    localparam int MUL_W      = 33;
    localparam int ACC_W      = 64;
    // integral sum before clamping
    localparam int INT_SUM_W  = INT_W + 2;
    // accumulator after rounding to Q1.14
    localparam int RND_SHIFT  = 18;
    localparam int RND_W      = ACC_W - RND_SHIFT;
    localparam int INC_SHIFT  = 12;
    localparam int SLEW_SHIFT = 16;
    // slew bound compare width
    localparam int LIM_W      = SLEW_W + 2;

    localparam logic signed [INT_W-1:0]  INTEGRAL_LOW   = -32'sd1048576;
    localparam logic signed [INT_W-1:0]  INTEGRAL_HIGH  = 32'sd1048576;
    localparam logic signed [ACC_W-1:0]  ROUND_BIAS     = 64'sd131072;
    localparam logic [VEL_W:0]           KICK_SPEED_MIN = 17'd82;
    localparam logic signed [DUTY_W-1:0] DUTY_FLOOR_RST = -16'sd16384;
    localparam logic signed [DUTY_W-1:0] DUTY_CEIL_RST  = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF_GAIN,
        REG_FF_OFFSET,
        REG_PROP_GAIN,
        REG_INT_GAIN,
        REG_DUTY_FLOOR,
        REG_DUTY_CEILING,
        REG_SLEW_RATE,
        REG_KICK_DUTY
    } reg_index_t;

    typedef enum logic {
        CMD_RUN   = 1'b0,
        CMD_CLEAR = 1'b1
    } command_t;

    typedef enum logic {
        STATUS_OK      = 1'b0,
        STATUS_INVALID = 1'b1
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ERR,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_I,
        ST_SLEW,
        ST_CLAMP,
        ST_LIMIT,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MSEL_ERR_DT,
        MSEL_FF,
        MSEL_PROP,
        MSEL_INT,
        MSEL_SLEW
    } mul_sel_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] ff_gain;
        logic signed [GAIN_W-1:0] ff_offset;
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] int_gain;
        logic signed [DUTY_W-1:0] duty_floor;
        logic signed [DUTY_W-1:0] duty_ceiling;
        logic [SLEW_W-1:0]        slew_rate;
        logic [KICK_W-1:0]        kick_duty;
    } cfg_regs_t;

    typedef struct packed {
        logic step_valid;
        logic step_short;
        logic result_ready;
    } seq_req_t;

    typedef struct packed {
        state_t   state;
        logic     in_ready;
        logic     out_valid;
        logic     mul_en;
        mul_sel_t mul_sel;
    } seq_ctrl_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [VEL_W-1:0] target;
        logic [DT_W-1:0]         dt;
        logic signed [INT_W-1:0] integral;
    } mul_src_t;

endpackage

[rtl/wvpi_if.sv]
interface wvpi_step_if;
    import wvpi_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [VEL_W-1:0] target_velocity;
    logic signed [VEL_W-1:0] measured_velocity;
    logic [DT_W-1:0]         time_step;

    modport source (
        output valid, command, target_velocity, measured_velocity, time_step,
        input  ready
    );
    modport sink (
        input  valid, command, target_velocity, measured_velocity, time_step,
        output ready
    );
endinterface

interface wvpi_result_if;
    import wvpi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DUTY_W-1:0] duty;
    logic                     status;

    modport source (
        output valid, duty, status,
        input  ready
    );
    modport sink (
        input  valid, duty, status,
        output ready
    );
endinterface

interface wvpi_cfg_if;
    import wvpi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/wvpi_cfg.sv]
module wvpi_cfg (
    input  logic               clk,
    input  logic               rst_n,
    wvpi_cfg_if.sink           cfg,
    output wvpi_pkg::cfg_regs_t regs
);
    import wvpi_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_FF_GAIN:      regs_next.ff_gain      = cfg.data;
                REG_FF_OFFSET:    regs_next.ff_offset    = cfg.data;
                REG_PROP_GAIN:    regs_next.prop_gain    = cfg.data;
                REG_INT_GAIN:     regs_next.int_gain     = cfg.data;
                REG_DUTY_FLOOR:   regs_next.duty_floor   = cfg.data[DUTY_W-1:0];
                REG_DUTY_CEILING: regs_next.duty_ceiling = cfg.data[DUTY_W-1:0];
                REG_SLEW_RATE:    regs_next.slew_rate    = cfg.data[SLEW_W-1:0];
                REG_KICK_DUTY:    regs_next.kick_duty    = cfg.data[KICK_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ff_gain      <= '0;
            regs_reg.ff_offset    <= '0;
            regs_reg.prop_gain    <= '0;
            regs_reg.int_gain     <= '0;
            regs_reg.duty_floor   <= DUTY_FLOOR_RST;
            regs_reg.duty_ceiling <= DUTY_CEIL_RST;
            regs_reg.slew_rate    <= '0;
            regs_reg.kick_duty    <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

[rtl/wvpi_mul.sv]
module wvpi_mul (
    input  logic                               clk,
    input  logic                               en,
    input  wvpi_pkg::mul_sel_t                 sel,
    input  wvpi_pkg::mul_src_t                 src,
    input  wvpi_pkg::cfg_regs_t                regs,
    output logic signed [wvpi_pkg::ACC_W-1:0]  prod_reg
);
    import wvpi_pkg::*;

    logic signed [MUL_W-1:0]   op_a;
    logic signed [MUL_W-1:0]   op_b;
    logic signed [2*MUL_W-1:0] prod_full;

    always_comb
    begin
        unique case (sel)
            MSEL_ERR_DT:
            begin
                op_a = MUL_W'(src.err);
                op_b = $signed(MUL_W'(src.dt));
            end
            MSEL_FF:
            begin
                op_a = MUL_W'(regs.ff_gain);
                op_b = MUL_W'(src.target);
            end
            MSEL_PROP:
            begin
                op_a = MUL_W'(regs.prop_gain);
                op_b = MUL_W'(src.err);
            end
            MSEL_INT:
            begin
                op_a = MUL_W'(regs.int_gain);
                op_b = MUL_W'(src.integral);
            end
            MSEL_SLEW:
            begin
                op_a = $signed(MUL_W'(regs.slew_rate));
                op_b = $signed(MUL_W'(src.dt));
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_full = op_a * op_b;

    // every product used here fits in the accumulator width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_full[ACC_W-1:0];
        end
    end

endmodule

[rtl/wvpi_seq.sv]
module wvpi_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  wvpi_pkg::seq_req_t  req,
    output wvpi_pkg::seq_ctrl_t ctrl
);
    import wvpi_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctrl.state     = state_reg;
        ctrl.in_ready  = 1'b0;
        ctrl.out_valid = 1'b0;
        ctrl.mul_en    = 1'b0;
        ctrl.mul_sel   = MSEL_ERR_DT;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (req.step_valid)
                begin
                    state_next = req.step_short ? ST_OUT : ST_MUL_ERR;
                end
            end
            ST_MUL_ERR:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MSEL_ERR_DT;
                state_next   = ST_INTEG;
            end
            ST_INTEG:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MSEL_FF;
                state_next   = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MSEL_PROP;
                state_next   = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                // integral is already updated here
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MSEL_INT;
                state_next   = ST_SLEW;
            end
            ST_SLEW:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MSEL_SLEW;
                state_next   = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                state_next = ST_LIMIT;
            end
            ST_LIMIT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                ctrl.out_valid = 1'b1;
                if (req.result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/wheel_velocity_pi_slew_controller_unit.sv]
// Channel   Role     Payload
// step      sink     command, target_velocity, measured_velocity, time_step
// result    source   duty, status
// cfg       sink     index, data (always ready)
//
// A run step goes through MUL_ERR, INTEG, MUL_P, MUL_I, SLEW, CLAMP and LIMIT to
// OUT, and the next step is taken in the cycle after the result beat. The five
// products go one after another through the single 33x33 multiplier.
// A clear command or an invalid step shows its result in the cycle after the beat.
// Reset loads the register defaults and zeroes the integral and last duty.
// A stalled result holds the block; no step is taken until the result beat.
module wheel_velocity_pi_slew_controller_unit (
    input  logic          clk,
    input  logic          rst_n,
    wvpi_step_if.sink     step,
    wvpi_result_if.source result,
    wvpi_cfg_if.sink      cfg
);
    import wvpi_pkg::*;

    cfg_regs_t regs;
    seq_req_t  req;
    seq_ctrl_t ctrl;
    mul_src_t  src;

    logic signed [VEL_W-1:0]  target_reg;
    logic signed [VEL_W-1:0]  measured_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [INT_W-1:0]  integral_reg;
    logic signed [DUTY_W-1:0] prev_duty_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [DUTY_W-1:0] bounded_reg;
    logic [SLEW_W-1:0]        max_delta_reg;
    logic signed [DUTY_W-1:0] duty_reg;
    logic                     status_reg;

    logic                     step_fire;
    logic                     is_clear;
    logic                     invalid;
    logic signed [ERR_W-1:0]  err;
    logic                     target_zero;
    logic signed [ACC_W-1:0]  off_ext;
    logic signed [ACC_W-1:0]  acc_init;
    logic signed [ACC_W-1:0]  inc;
    logic signed [INT_SUM_W-1:0] int_sum;
    logic signed [INT_W-1:0]  int_next;
    logic signed [ACC_W-1:0]  rnd_full;
    logic signed [RND_W-1:0]  rnd;
    logic signed [DUTY_W-1:0] bounded;
    logic signed [ERR_W-1:0]  delta;
    logic signed [LIM_W-1:0]  delta_ext;
    logic signed [LIM_W-1:0]  md;
    logic signed [LIM_W-1:0]  up_duty;
    logic signed [LIM_W-1:0]  dn_duty;
    logic signed [DUTY_W-1:0] slewed;
    logic [VEL_W:0]           abs_target;
    logic [VEL_W:0]           abs_meas;
    logic [DUTY_W:0]          abs_slewed;
    logic signed [DUTY_W-1:0] kick_pos;
    logic                     kick_on;
    logic signed [DUTY_W-1:0] duty_final;

    assign step_fire = step.valid && step.ready;
    assign is_clear  = (step.command == CMD_CLEAR);
    assign invalid   = (regs.duty_floor > regs.duty_ceiling)
                    || ($signed({1'b0, regs.kick_duty}) > regs.duty_ceiling)
                    || (step.time_step == '0);

    assign req.step_valid   = step.valid;
    assign req.step_short   = is_clear || invalid;
    assign req.result_ready = result.ready;

    assign step.ready    = ctrl.in_ready;
    assign result.valid  = ctrl.out_valid;
    assign result.duty   = duty_reg;
    assign result.status = status_reg;

    wvpi_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    wvpi_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctrl  (ctrl)
    );

    assign src.err      = err;
    assign src.target   = target_reg;
    assign src.dt       = dt_reg;
    assign src.integral = integral_reg;

    wvpi_mul u_mul (
        .clk      (clk),
        .en       (ctrl.mul_en),
        .sel      (ctrl.mul_sel),
        .src      (src),
        .regs     (regs),
        .prod_reg (prod_reg)
    );

    assign err         = ERR_W'(target_reg) - ERR_W'(measured_reg);
    assign target_zero = (target_reg == '0);

    // integral: add floor(err*dt / 2^12), clamp, clear on zero target
    assign inc     = prod_reg >>> INC_SHIFT;
    assign int_sum = INT_SUM_W'(integral_reg) + $signed(inc[INT_SUM_W-1:0]);

    always_comb
    begin
        priority if (target_zero)
        begin
            int_next = '0;
        end
        else if (int_sum < INT_SUM_W'(INTEGRAL_LOW))
        begin
            int_next = INTEGRAL_LOW;
        end
        else if (int_sum > INT_SUM_W'(INTEGRAL_HIGH))
        begin
            int_next = INTEGRAL_HIGH;
        end
        else
        begin
            int_next = int_sum[INT_W-1:0];
        end
    end

    // static offset with the target's sign, scaled to 2^-32
    assign off_ext = $signed({{(ACC_W-GAIN_W-16){regs.ff_offset[GAIN_W-1]}},
                              regs.ff_offset, 16'b0});

    always_comb
    begin
        priority if (target_zero)
        begin
            acc_init = '0;
        end
        else if (target_reg[VEL_W-1])
        begin
            acc_init = -off_ext;
        end
        else
        begin
            acc_init = off_ext;
        end
    end

    // round to Q1.14 and clamp to the duty range
    assign rnd_full = acc_reg + ROUND_BIAS;
    assign rnd      = rnd_full[ACC_W-1:RND_SHIFT];

    always_comb
    begin
        priority if (rnd < RND_W'(regs.duty_floor))
        begin
            bounded = regs.duty_floor;
        end
        else if (rnd > RND_W'(regs.duty_ceiling))
        begin
            bounded = regs.duty_ceiling;
        end
        else
        begin
            bounded = rnd[DUTY_W-1:0];
        end
    end

    // slew limit against the last duty
    assign delta     = ERR_W'(bounded_reg) - ERR_W'(prev_duty_reg);
    assign delta_ext = LIM_W'(delta);
    assign md        = $signed(LIM_W'(max_delta_reg));
    assign up_duty   = LIM_W'(prev_duty_reg) + md;
    assign dn_duty   = LIM_W'(prev_duty_reg) - md;

    always_comb
    begin
        priority if (delta_ext > md)
        begin
            slewed = up_duty[DUTY_W-1:0];
        end
        else if (delta_ext < -md)
        begin
            slewed = dn_duty[DUTY_W-1:0];
        end
        else
        begin
            slewed = bounded_reg;
        end
    end

    // breakaway assist after a true stop
    assign abs_target = target_reg[VEL_W-1] ? -(VEL_W+1)'(target_reg)
                                            : (VEL_W+1)'(target_reg);
    assign abs_meas   = measured_reg[VEL_W-1] ? -(VEL_W+1)'(measured_reg)
                                              : (VEL_W+1)'(measured_reg);
    assign abs_slewed = slewed[DUTY_W-1] ? -(DUTY_W+1)'(slewed)
                                         : (DUTY_W+1)'(slewed);
    assign kick_pos   = $signed(DUTY_W'(regs.kick_duty));
    assign kick_on    = (abs_target >= KICK_SPEED_MIN) && (prev_duty_reg == '0)
                     && (abs_meas < KICK_SPEED_MIN) && (regs.kick_duty != '0)
                     && (abs_slewed < (DUTY_W+1)'(regs.kick_duty));

    always_comb
    begin
        priority if (target_zero)
        begin
            duty_final = '0;
        end
        else if (kick_on)
        begin
            duty_final = target_reg[VEL_W-1] ? -kick_pos : kick_pos;
        end
        else
        begin
            duty_final = slewed;
        end
    end

    // working registers and result
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            target_reg   <= step.target_velocity;
            measured_reg <= step.measured_velocity;
            dt_reg       <= step.time_step;
            duty_reg     <= '0;
            status_reg   <= (!is_clear && invalid) ? STATUS_INVALID : STATUS_OK;
        end
        unique case (ctrl.state)
            ST_INTEG:
            begin
                acc_reg <= acc_init;
            end
            ST_MUL_P, ST_MUL_I:
            begin
                acc_reg <= acc_reg + (prod_reg <<< 4);
            end
            ST_SLEW:
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            ST_CLAMP:
            begin
                bounded_reg   <= bounded;
                max_delta_reg <= prod_reg[SLEW_W+SLEW_SHIFT-1:SLEW_SHIFT];
            end
            ST_LIMIT:
            begin
                duty_reg   <= duty_final;
                status_reg <= STATUS_OK;
            end
            default:
            begin
            end
        endcase
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg  <= '0;
            prev_duty_reg <= '0;
        end
        else if (step_fire && is_clear)
        begin
            integral_reg  <= '0;
            prev_duty_reg <= '0;
        end
        else if (ctrl.state == ST_INTEG)
        begin
            integral_reg <= int_next;
        end
        else if (ctrl.state == ST_LIMIT)
        begin
            prev_duty_reg <= duty_final;
        end
    end

    a_int_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (integral_reg >= INTEGRAL_LOW) && (integral_reg <= INTEGRAL_HIGH))
        else $error("integral outside its clamp range");

    a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && req.step_short |=> result.valid)
        else $error("clear or invalid step did not answer at once");

    a_run_path: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && !req.step_short |=> !result.valid && ctrl.state == ST_MUL_ERR)
        else $error("run step skipped the sequence");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == STATUS_INVALID |-> result.duty == '0)
        else $error("invalid result carries a nonzero duty");

    a_prev_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_fire && ctrl.state != ST_LIMIT |=> $stable(prev_duty_reg))
        else $error("last duty changed outside a step");

endmodule
